// File: hdl/dwdiv_pkg.sv
package dwdiv_pkg;

  localparam int unsigned DataW = 64;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_DIV_ZERO = 2'd1,
    STATUS_OVERFLOW = 2'd2
  } status_e;

  typedef struct packed {
    logic [DataW-1:0] dividend_high;
    logic [DataW-1:0] dividend_low;
    logic [DataW-1:0] divisor;
  } in_word_t;

  typedef struct packed {
    logic [DataW-1:0] quotient;
    logic [DataW-1:0] remainder;
    status_e          status;
  } out_word_t;

  // valid bit and error code that ride along with each stage
  typedef struct packed {
    logic    valid;
    status_e status;
  } stage_ctl_t;

endpackage

// File: hdl/dwdiv_check.sv
module dwdiv_check import dwdiv_pkg::*; #(
  parameter int unsigned DIGIT_BITS = 64
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  en_i,
  input  logic                  valid_i,
  input  in_word_t              in_i,
  output stage_ctl_t            ctl_o,
  output logic [DIGIT_BITS-1:0] rem_o,
  output logic [DIGIT_BITS-1:0] lo_o,
  output logic [DIGIT_BITS-1:0] div_o
);

  logic [DIGIT_BITS-1:0] hi, lo, dv;
  stage_ctl_t            ctl_d, ctl_q;
  logic [DIGIT_BITS-1:0] rem_q, lo_q, div_q;

  assign hi = in_i.dividend_high[DIGIT_BITS-1:0];
  assign lo = in_i.dividend_low[DIGIT_BITS-1:0];
  assign dv = in_i.divisor[DIGIT_BITS-1:0];

  always_comb begin
    ctl_d.valid = valid_i;
    if (dv == '0) begin
      ctl_d.status = STATUS_DIV_ZERO;
    end else if (hi >= dv) begin
      ctl_d.status = STATUS_OVERFLOW;
    end else begin
      ctl_d.status = STATUS_OK;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '{valid: 1'b0, status: STATUS_OK};
    end else if (en_i) begin
      ctl_q <= ctl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q <= hi;
      lo_q  <= lo;
      div_q <= dv;
    end
  end

  assign ctl_o = ctl_q;
  assign rem_o = rem_q;
  assign lo_o  = lo_q;
  assign div_o = div_q;

endmodule

// File: hdl/dwdiv_step.sv
module dwdiv_step import dwdiv_pkg::*; #(
  parameter int unsigned DIGIT_BITS = 64
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  en_i,
  input  stage_ctl_t            ctl_i,
  input  logic [DIGIT_BITS-1:0] rem_i,
  input  logic [DIGIT_BITS-1:0] lo_i,
  input  logic [DIGIT_BITS-1:0] div_i,
  output stage_ctl_t            ctl_o,
  output logic [DIGIT_BITS-1:0] rem_o,
  output logic [DIGIT_BITS-1:0] lo_o,
  output logic [DIGIT_BITS-1:0] div_o
);

  logic [DIGIT_BITS:0]   shifted, diff;
  logic                  take;
  logic [DIGIT_BITS-1:0] rem_d, lo_d;
  stage_ctl_t            ctl_q;
  logic [DIGIT_BITS-1:0] rem_q, lo_q, div_q;

  // lo shifts out dividend bits at the top and takes quotient bits at the bottom
  always_comb begin
    shifted = {rem_i, lo_i[DIGIT_BITS-1]};
    diff    = shifted - {1'b0, div_i};
    take    = !diff[DIGIT_BITS];
    rem_d   = take ? diff[DIGIT_BITS-1:0] : shifted[DIGIT_BITS-1:0];
    lo_d    = {lo_i[DIGIT_BITS-2:0], take};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '{valid: 1'b0, status: STATUS_OK};
    end else if (en_i) begin
      ctl_q <= ctl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q <= rem_d;
      lo_q  <= lo_d;
      div_q <= div_i;
    end
  end

  assign ctl_o = ctl_q;
  assign rem_o = rem_q;
  assign lo_o  = lo_q;
  assign div_o = div_q;

endmodule

// File: hdl/double_word_by_word_divider_unit.sv
// Unsigned division of a two-digit dividend by a one-digit divisor, pipelined
// as restoring long division with one quotient bit per stage. A new word is
// taken every cycle while the output register holds no unread result; each
// word passes through one check stage, DIGIT_BITS subtract stages and one
// output register. The whole pipeline advances together and holds while an
// unread result sits in the output register. Inputs are cut to DIGIT_BITS bits.
// A zero divisor gives status 1, a high digit not below the divisor gives
// status 2; both return zero quotient and remainder.
module double_word_by_word_divider_unit import dwdiv_pkg::*; #(
  parameter int unsigned DIGIT_BITS = 64
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_word_t  in_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_word_t out_o
);

  logic                  adv;
  stage_ctl_t            ctl_s [0:DIGIT_BITS];
  logic [DIGIT_BITS-1:0] rem_s [0:DIGIT_BITS];
  logic [DIGIT_BITS-1:0] lo_s  [0:DIGIT_BITS];
  logic [DIGIT_BITS-1:0] div_s [0:DIGIT_BITS];
  logic [DIGIT_BITS:0]   valid_vec;
  logic                  out_valid_q;
  out_word_t             out_d, out_q;

  assign adv        = !out_valid_q || out_ready_i;
  assign in_ready_o = adv;

  dwdiv_check #(.DIGIT_BITS(DIGIT_BITS)) u_check (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (adv),
    .valid_i(in_valid_i),
    .in_i   (in_i),
    .ctl_o  (ctl_s[0]),
    .rem_o  (rem_s[0]),
    .lo_o   (lo_s[0]),
    .div_o  (div_s[0])
  );

  for (genvar k = 0; k < DIGIT_BITS; k++) begin : g_step
    dwdiv_step #(.DIGIT_BITS(DIGIT_BITS)) u_step (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (adv),
      .ctl_i  (ctl_s[k]),
      .rem_i  (rem_s[k]),
      .lo_i   (lo_s[k]),
      .div_i  (div_s[k]),
      .ctl_o  (ctl_s[k+1]),
      .rem_o  (rem_s[k+1]),
      .lo_o   (lo_s[k+1]),
      .div_o  (div_s[k+1])
    );
  end

  for (genvar k = 0; k <= DIGIT_BITS; k++) begin : g_valid
    assign valid_vec[k] = ctl_s[k].valid;
  end

  always_comb begin
    out_d.status = ctl_s[DIGIT_BITS].status;
    if (ctl_s[DIGIT_BITS].status == STATUS_OK) begin
      out_d.quotient  = DataW'(lo_s[DIGIT_BITS]);
      out_d.remainder = DataW'(rem_s[DIGIT_BITS]);
    end else begin
      out_d.quotient  = '0;
      out_d.remainder = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= ctl_s[DIGIT_BITS].valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  // error results carry no quotient or remainder
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_o.status != STATUS_OK |->
      out_o.quotient == '0 && out_o.remainder == '0)
    else $error("error word with nonzero data");

  // results never exceed the digit width
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_o.quotient >> DIGIT_BITS) == '0 &&
      (out_o.remainder >> DIGIT_BITS) == '0)
    else $error("result wider than a digit");

  // a held output freezes every stage
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> $stable(valid_vec))
    else $error("pipeline moved during stall");

endmodule
